@@ src/tcm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_pkg: shared types and constants of the tilt to cursor motion block
// op codes, register indexes, widths and configuration register set
// ----------------------------------------------------------------------------
package tcm_pkg;

	localparam int ANGLE_W = 16;
	localparam int FILT_W  = 24;
	localparam int MOVE_W  = 8;
	localparam int CFG_W   = 15;
	localparam int IDX_W   = 2;

	localparam int FILT_MAX = 8388607;
	localparam int FILT_MIN = -8388608;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_CAL     = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [IDX_W-1:0] REG_FILTER_GAIN = 2'd0;
	localparam logic [IDX_W-1:0] REG_DEADZONE    = 2'd1;
	localparam logic [IDX_W-1:0] REG_SENSITIVITY = 2'd2;
	localparam logic [IDX_W-1:0] REG_MAX_STEP    = 2'd3;

	typedef struct packed {
		logic [7:0]  filter_gain;
		logic [14:0] deadzone;
		logic [7:0]  sensitivity;
		logic [6:0]  max_step;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		filter_gain: 8'd51,
		deadzone:    15'd384,
		sensitivity: 8'd56,
		max_step:    7'd20
	};

endpackage
`default_nettype wire

@@ src/tcm_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_filter: one axis of the tilt low-pass
// wraps the deviation from center into one half turn and steps the filter
// ----------------------------------------------------------------------------
module tcm_filter #(
	parameter int ANGLE_FRAC_BITS  = 7,
	parameter int FILTER_FRAC_BITS = 8
) (
	input  wire logic signed [tcm_pkg::ANGLE_W-1:0] angle,
	input  wire logic signed [tcm_pkg::ANGLE_W-1:0] center,
	input  wire logic signed [tcm_pkg::FILT_W-1:0]  state,
	input  wire logic        [7:0]                  gain,
	output      logic signed [tcm_pkg::FILT_W-1:0]  next_state
);
	import tcm_pkg::*;

	// 360 << A needs 9 + A bits, plus sign and the headroom of a difference
	localparam int WRAP_W = ANGLE_FRAC_BITS + 11;
	localparam int TGT_W  = WRAP_W + FILTER_FRAC_BITS;
	localparam int DIFF_W = ((TGT_W > FILT_W) ? TGT_W : FILT_W) + 1;
	localparam int PROD_W = DIFF_W + 9;
	localparam int STEP_W = PROD_W - 8;
	localparam int NEXT_W = STEP_W + 1;

	localparam logic signed [WRAP_W-1:0] HALF_TURN = WRAP_W'(180 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [WRAP_W-1:0] FULL_TURN = WRAP_W'(360 * (1 << ANGLE_FRAC_BITS));
	localparam logic signed [NEXT_W-1:0] SAT_HI    = NEXT_W'(FILT_MAX);
	localparam logic signed [NEXT_W-1:0] SAT_LO    = NEXT_W'(FILT_MIN);

	logic signed [WRAP_W-1:0] dev;
	logic signed [WRAP_W-1:0] dev_wrap;
	logic signed [TGT_W-1:0]  target;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [STEP_W-1:0] step;
	logic signed [NEXT_W-1:0] sum;

	always_comb begin
		dev = WRAP_W'(angle) - WRAP_W'(center);
		if (dev > HALF_TURN) begin
			dev_wrap = dev - FULL_TURN;
		end else if (dev < -HALF_TURN) begin
			dev_wrap = dev + FULL_TURN;
		end else begin
			dev_wrap = dev;
		end
	end

	assign target   = TGT_W'(dev_wrap) <<< FILTER_FRAC_BITS;
	assign diff     = DIFF_W'(target) - DIFF_W'(state);
	assign prod     = PROD_W'(diff) * PROD_W'(signed'({1'b0, gain}));
	// round half up, then floor by the arithmetic shift
	assign prod_rnd = prod + PROD_W'(128);
	assign step     = STEP_W'(prod_rnd >>> 8);
	assign sum      = NEXT_W'(state) + NEXT_W'(step);

	always_comb begin
		if (sum > SAT_HI) begin
			next_state = FILT_W'(SAT_HI);
		end else if (sum < SAT_LO) begin
			next_state = FILT_W'(SAT_LO);
		end else begin
			next_state = FILT_W'(sum);
		end
	end

endmodule
`default_nettype wire

@@ src/tcm_motion.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_motion: one axis of deadzone, sensitivity scale and clamp
// turns a filtered deviation into a signed cursor step
// ----------------------------------------------------------------------------
module tcm_motion #(
	parameter int ANGLE_FRAC_BITS  = 7,
	parameter int FILTER_FRAC_BITS = 8
) (
	input  wire logic signed [tcm_pkg::FILT_W-1:0] filt,
	input  wire tcm_pkg::cfg_t                      cfg,
	output      logic signed [tcm_pkg::MOVE_W-1:0]  step
);
	import tcm_pkg::*;

	localparam int DZ_W   = 15 + FILTER_FRAC_BITS;
	localparam int MAG_W  = (DZ_W > FILT_W) ? DZ_W : FILT_W;
	localparam int PROD_W = MAG_W + 8;
	localparam int SHIFT  = 8 + ANGLE_FRAC_BITS + FILTER_FRAC_BITS;

	logic [FILT_W-1:0] mag;
	logic [MAG_W-1:0]  mag_ext;
	logic [MAG_W-1:0]  dz;
	logic [MAG_W-1:0]  excess;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] q;
	logic [6:0]        q_sat;

	// most negative value maps onto 2^23, still right as unsigned
	assign mag     = filt[FILT_W-1] ? FILT_W'(-filt) : filt;
	assign mag_ext = MAG_W'(mag);
	assign dz      = MAG_W'(cfg.deadzone) << FILTER_FRAC_BITS;
	assign excess  = (mag_ext > dz) ? (mag_ext - dz) : '0;
	assign prod    = PROD_W'(excess) * PROD_W'(cfg.sensitivity);
	assign q       = prod >> SHIFT;
	assign q_sat   = (q > PROD_W'(cfg.max_step)) ? cfg.max_step : q[6:0];
	assign step    = filt[FILT_W-1] ? -signed'({1'b0, q_sat}) : signed'({1'b0, q_sat});

endmodule
`default_nettype wire

@@ src/tilt_to_cursor_motion.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_to_cursor_motion: roll and pitch angles to relative cursor motion
// per-axis center, wrap, low-pass, deadzone, scale and clamp
// ----------------------------------------------------------------------------
//  channel  | signals                                        | handshake
//  ---------+------------------------------------------------+--------------
//  input    | op, roll_angle, pitch_angle, host_connected    | in_valid/in_stall
//  output   | move_x, move_y, send                           | out_valid/out_stall
//  config   | cfg_index, cfg_data                            | cfg_write_en
//
//  one transaction per cycle sustained while out_stall is low; a result passes
//  the input, filter and result registers before out_valid rises for it
//  the filter state loop closes from the state registers through the gain multiplier
//  arst_n clears valids, centers, filters and loads register defaults
//  stages advance independently, so bubbles collapse when out_stall is high
// ----------------------------------------------------------------------------
module tilt_to_cursor_motion #(
	parameter int ANGLE_FRAC_BITS  = 7,
	parameter int FILTER_FRAC_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic [1:0]                          op,
	input  wire logic signed [tcm_pkg::ANGLE_W-1:0]  roll_angle,
	input  wire logic signed [tcm_pkg::ANGLE_W-1:0]  pitch_angle,
	input  wire logic                                host_connected,
	// output channel
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic signed [tcm_pkg::MOVE_W-1:0]   move_x,
	output      logic signed [tcm_pkg::MOVE_W-1:0]   move_y,
	output      logic                                send,
	// configuration write port
	input  wire logic                                cfg_write_en,
	input  wire logic [tcm_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [tcm_pkg::CFG_W-1:0]           cfg_data
);
	import tcm_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_FILTER_GAIN: cfg_q.filter_gain <= cfg_data[7:0];
				REG_DEADZONE:    cfg_q.deadzone    <= cfg_data[14:0];
				REG_SENSITIVITY: cfg_q.sensitivity <= cfg_data[7:0];
				REG_MAX_STEP:    cfg_q.max_step    <= cfg_data[6:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	// stage enables, each stage moves when its slot downstream is free
	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	logic adv_s1;

	assign en_s3  = !v_s3 || !out_stall;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign adv_s1 = v_s1 && en_s2;
	assign in_stall = !en_s1;

	// input register
	logic [1:0]                  op_s1;
	logic signed [ANGLE_W-1:0]   roll_s1;
	logic signed [ANGLE_W-1:0]   pitch_s1;
	logic                        host_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			op_s1    <= op;
			roll_s1  <= roll_angle;
			pitch_s1 <= pitch_angle;
			host_s1  <= host_connected;
		end
	end

	// centers and filter state
	logic signed [ANGLE_W-1:0] roll_center_q;
	logic signed [ANGLE_W-1:0] pitch_center_q;
	logic signed [FILT_W-1:0]  froll_q;
	logic signed [FILT_W-1:0]  fpitch_q;
	logic signed [FILT_W-1:0]  froll_next;
	logic signed [FILT_W-1:0]  fpitch_next;

	tcm_filter #(
		.ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
		.FILTER_FRAC_BITS (FILTER_FRAC_BITS)
	) u_filter_roll (
		.angle      (roll_s1),
		.center     (roll_center_q),
		.state      (froll_q),
		.gain       (cfg_q.filter_gain),
		.next_state (froll_next)
	);

	tcm_filter #(
		.ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
		.FILTER_FRAC_BITS (FILTER_FRAC_BITS)
	) u_filter_pitch (
		.angle      (pitch_s1),
		.center     (pitch_center_q),
		.state      (fpitch_q),
		.gain       (cfg_q.filter_gain),
		.next_state (fpitch_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_center_q  <= '0;
			pitch_center_q <= '0;
			froll_q        <= '0;
			fpitch_q       <= '0;
		end else if (adv_s1) begin
			if (op_s1 == OP_TICK) begin
				froll_q  <= froll_next;
				fpitch_q <= fpitch_next;
			end else if (op_s1 == OP_CAL || op_s1 == OP_RESTART) begin
				roll_center_q  <= roll_s1;
				pitch_center_q <= pitch_s1;
				// restart also drops the filter history
				if (op_s1 == OP_RESTART) begin
					froll_q  <= '0;
					fpitch_q <= '0;
				end
			end
		end
	end

	// filter register: new filter values of a tick, zero motion otherwise
	logic                       tick_s2;
	logic                       host_s2;
	logic signed [FILT_W-1:0]   froll_s2;
	logic signed [FILT_W-1:0]   fpitch_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tick_s2   <= (op_s1 == OP_TICK);
			host_s2   <= host_s1;
			froll_s2  <= froll_next;
			fpitch_s2 <= fpitch_next;
		end
	end

	// deadzone, scale and clamp per axis
	logic signed [MOVE_W-1:0] step_roll;
	logic signed [MOVE_W-1:0] step_pitch;
	logic signed [MOVE_W-1:0] mx;
	logic signed [MOVE_W-1:0] my;

	tcm_motion #(
		.ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
		.FILTER_FRAC_BITS (FILTER_FRAC_BITS)
	) u_motion_roll (
		.filt (froll_s2),
		.cfg  (cfg_q),
		.step (step_roll)
	);

	tcm_motion #(
		.ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
		.FILTER_FRAC_BITS (FILTER_FRAC_BITS)
	) u_motion_pitch (
		.filt (fpitch_s2),
		.cfg  (cfg_q),
		.step (step_pitch)
	);

	// horizontal comes from pitch with its sign flipped
	assign mx = tick_s2 ? -step_pitch : '0;
	assign my = tick_s2 ? step_roll : '0;

	// result register
	logic signed [MOVE_W-1:0] move_x_s3;
	logic signed [MOVE_W-1:0] move_y_s3;
	logic                     send_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			move_x_s3 <= mx;
			move_y_s3 <= my;
			send_s3   <= host_s2 && (mx != '0 || my != '0);
		end
	end

	assign out_valid = v_s3;
	assign move_x    = move_x_s3;
	assign move_y    = move_y_s3;
	assign send      = send_s3;

`ifndef SYNTHESIS
	// a report only goes out with some motion in it
	a_send_has_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && send) |-> (move_x != '0 || move_y != '0))
		else $error("send raised with zero motion");

	// both steps stay within the clamp
	a_move_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (move_x <= signed'({1'b0, cfg_q.max_step})
			&& move_x >= -signed'({1'b0, cfg_q.max_step})
			&& move_y <= signed'({1'b0, cfg_q.max_step})
			&& move_y >= -signed'({1'b0, cfg_q.max_step})))
		else $error("motion beyond max_step");

	// restart leaves both filters cleared
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 == OP_RESTART) |=> (froll_q == '0 && fpitch_q == '0))
		else $error("filters not cleared on restart");

	// backpressure only when the input register holds a stuck transaction
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_stall))
		else $error("input stalled with free pipeline slot");
`endif

endmodule
`default_nettype wire
